>>> sv/url_form_args_recoder_assert.svh
`ifndef URL_FORM_ARGS_RECODER_ASSERT_SVH
`define URL_FORM_ARGS_RECODER_ASSERT_SVH

// same-cycle implication, off during reset
`define UFAR_ASSERT_NOW(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("ufar assertion failed");

// next-cycle implication, off during reset
`define UFAR_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("ufar assertion failed");

// next-cycle implication that also holds across reset
`define UFAR_ASSERT_ALWAYS(label, clk, a, c) \
  label: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("ufar assertion failed");

`endif

>>> sv/ufar_pkg.sv
package ufar_pkg;

  localparam int unsigned BURST_LEN = 6;
  localparam int unsigned CNT_W     = 3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_QUEST = 8'h3f;

  typedef struct packed {
    logic [BURST_LEN-1:0][7:0] data;
    logic [CNT_W-1:0]          cnt;
    logic                      last;
  } burst_t;

  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      cnt;
  } raw_t;

  function automatic logic is_safe(input logic [7:0] b);
    return (b == 8'h21) || (b == 8'h24) ||
           (b >= 8'h28 && b <= 8'h2a) || (b >= 8'h2c && b <= 8'h3a) ||
           (b >= 8'h41 && b <= 8'h5a) || (b == 8'h5f) ||
           (b >= 8'h61 && b <= 8'h7a) || (b == 8'h7c) || (b == 8'h7e);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [7:0] v;
    v = 8'h00;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = b - 8'h30;
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = b - 8'h37;
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = b - 8'h57;
    end
    return v[3:0];
  endfunction

  function automatic logic [7:0] upper_ascii(input logic [7:0] b);
    if (b >= 8'h61 && b <= 8'h7a) begin
      return b - 8'h20;
    end
    return b;
  endfunction

  // uppercase hex digit character
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return 8'h30 + {4'h0, n};
    end
    return 8'h37 + {4'h0, n};
  endfunction

  function automatic raw_t recode_raw(input logic [7:0] b);
    raw_t r;
    r = '0;
    if (is_safe(b) || b == CH_AMP || b == CH_EQ || b == CH_SEMI ||
        b == CH_PLUS || b == CH_QUEST) begin
      r.data[0] = b;
      r.cnt     = 2'd1;
    end else if (b == CH_SPACE) begin
      r.data[0] = CH_PLUS;
      r.cnt     = 2'd1;
    end else begin
      r.data[0] = CH_PCT;
      r.data[1] = hex_char(b[7:4]);
      r.data[2] = hex_char(b[3:0]);
      r.cnt     = 2'd3;
    end
    return r;
  endfunction

endpackage

>>> sv/ufar_recode.sv
module ufar_recode (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output ufar_pkg::burst_t  burst
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_PCT   = 3'b010,
    PH_DIGIT = 3'b100
  } phase_t;

  phase_t          phase;
  phase_t          phase_next;
  logic [7:0]      held_digit;
  ufar_pkg::raw_t  raw;
  logic [7:0]      val;

  always_comb begin
    raw        = ufar_pkg::recode_raw(in_byte);
    val        = {ufar_pkg::hex_value(held_digit), ufar_pkg::hex_value(in_byte)};
    burst      = '0;
    burst.last = in_last;
    phase_next = PH_IDLE;
    unique case (phase)
      PH_PCT: begin
        if (in_last) begin
          // lone percent near the end: %25 then the final byte as raw
          burst.data = {raw.data, ufar_pkg::CH_FIVE, ufar_pkg::CH_TWO, ufar_pkg::CH_PCT};
          burst.cnt  = 3'd3 + {1'b0, raw.cnt};
        end else begin
          phase_next = PH_DIGIT;
        end
      end
      PH_DIGIT: begin
        if (ufar_pkg::is_safe(val)) begin
          burst.data[0] = val;
          burst.cnt     = 3'd1;
        end else if (val == ufar_pkg::CH_SPACE) begin
          burst.data[0] = ufar_pkg::CH_PLUS;
          burst.cnt     = 3'd1;
        end else begin
          burst.data[0] = ufar_pkg::CH_PCT;
          burst.data[1] = ufar_pkg::upper_ascii(held_digit);
          burst.data[2] = ufar_pkg::upper_ascii(in_byte);
          burst.cnt     = 3'd3;
        end
      end
      default: begin
        if (in_byte == ufar_pkg::CH_PCT && !in_last) begin
          phase_next = PH_PCT;
        end else begin
          burst.data[2:0] = raw.data;
          burst.cnt       = {1'b0, raw.cnt};
        end
      end
    endcase
    if (in_last) begin
      phase_next = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (step) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && phase == PH_PCT && !in_last) begin
      held_digit <= in_byte;
    end
  end

endmodule

>>> sv/ufar_obuf.sv
module ufar_obuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  ufar_pkg::burst_t  burst,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [7:0]        out_byte,
  output logic              out_last,
  output logic              ready
);

  logic [ufar_pkg::BURST_LEN-1:0][7:0] data;
  logic [ufar_pkg::CNT_W-1:0]          cnt;
  logic                                last;
  logic                                pop;

  assign out_valid = (cnt != '0);
  assign out_byte  = data[0];
  assign out_last  = last && (cnt == ufar_pkg::CNT_W'(1));
  assign pop       = out_valid && !out_stall;
  // free now, or the last word leaves this cycle
  assign ready     = (cnt == '0) || ((cnt == ufar_pkg::CNT_W'(1)) && !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= burst.cnt;
    end else if (pop) begin
      cnt <= cnt - ufar_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= burst.data;
      last <= burst.last;
    end else if (pop) begin
      data <= {8'h00, data[ufar_pkg::BURST_LEN-1:1]};
    end
  end

endmodule

>>> sv/url_form_args_recoder.sv
// Recodes a form/URL-argument string to normalized percent-encoding, one byte
// in and one byte out per word. An input byte is registered, then recoded in
// one pass into a burst of zero to six output bytes that a shift buffer hands
// out one per cycle while out_stall is low; a byte goes through the input
// register, then the shift buffer. A new input word is taken every cycle
// while each yields at most one output byte and out_stall is low; a word that
// expands to k bytes holds the single-byte output port until all k have left.
// Bytes of a pending %XX escape give no output until it resolves.
module url_form_args_recoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic             in_full;
  logic [7:0]       byte_r;
  logic             last_r;
  logic             load;
  logic             buf_ready;
  logic             accept;
  ufar_pkg::burst_t burst;

  assign load     = in_full && buf_ready;
  assign in_stall = in_full && !buf_ready;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (load) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
  end

  ufar_recode u_recode (
    .clk     (clk),
    .rst     (rst),
    .step    (load),
    .in_byte (byte_r),
    .in_last (last_r),
    .burst   (burst)
  );

  ufar_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .burst     (burst),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .ready     (buf_ready)
  );

endmodule

>>> sv/ufar_checker.sv
`include "url_form_args_recoder_assert.svh"

module ufar_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_byte,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // a stalled output word stays up
  `UFAR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

  // and keeps its payload
  `UFAR_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable({out_byte, out_last}))

  // a stalled input word keeps its payload
  `UFAR_ASSERT_NEXT(a_in_stable, clk, rst, in_valid && in_stall, $stable({in_byte, in_last}))

  // input backs up only behind a pending output word
  `UFAR_ASSERT_NOW(a_stall_cause, clk, rst, in_stall, out_valid)

  // reset empties both sides
  `UFAR_ASSERT_ALWAYS(a_reset_empty, clk, rst, !out_valid && !in_stall)

endmodule

bind url_form_args_recoder ufar_checker u_checker (.*);
